### rtl/core/lbqs_pkg.sv
`default_nettype none
package lbqs_pkg;

  localparam logic [2:0] FUNC_INSERT   = 3'd0;
  localparam logic [2:0] FUNC_DELETE   = 3'd1;
  localparam logic [2:0] FUNC_QUANTILE = 3'd2;
  localparam logic [2:0] FUNC_CLEAR    = 3'd3;
  localparam logic [2:0] FUNC_MERGE    = 3'd4;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CLAMPED = 2'd1;
  localparam logic [1:0] STATUS_SAT     = 2'd2;

  localparam logic CFG_GAMMA     = 1'b0;
  localparam logic CFG_REP_SCALE = 1'b1;

  localparam int FACTOR_W = 31;
  localparam int BOUND_W  = 64;
  localparam int PROD_W   = BOUND_W + FACTOR_W;

  localparam logic [FACTOR_W-1:0] GAMMA_RESET     = 31'd1095433578;
  localparam logic [FACTOR_W-1:0] REP_SCALE_RESET = 31'd1063004406;

endpackage
`default_nettype wire

### rtl/core/log_bucket_quantile_sketch.sv
`default_nettype none
// Log-bucket quantile sketch: saturating counts over log-spaced buckets.
// Input channel in_valid/in_stall carries func, sample_value, q_fraction,
// merge_bucket and merge_amount; one result item per input on out_valid/
// out_stall with bucket_id, rep_value_q16, found and status.
// One item at a time: in_stall is high from acceptance until the result
// is loaded into the output register, and the next item can be taken in
// the cycle after that. A shared 32x31 multiplier computes the bucket
// boundaries, the quantile threshold and the representative value, each as
// a low partial product, a high partial product and their sum, so the cost
// is set by the walk: insert/delete search the buckets in order, quantile
// walks them adding up counts, merge adds at one bucket, clear rewrites
// every entry and the other codes go straight to the result.
// After reset the count memory is cleared one entry a cycle, with in_stall
// high throughout; configuration writes go through cfg_we/cfg_index/cfg_data
// between items, which the user keeps to; the block does not enforce it.
// When the receiver stalls, the result holds in the output register while
// the next item is taken; a finished result then waits until it drains.
module log_bucket_quantile_sketch #(
  parameter int BUCKET_COUNT = 2048,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [31:0] sample_value,
  input  wire logic [16:0] q_fraction,
  input  wire logic [10:0] merge_bucket,
  input  wire logic [31:0] merge_amount,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [10:0]      bucket_id,
  output logic [47:0]      rep_value_q16,
  output logic             found,
  output logic [1:0]       status,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [30:0] cfg_data
);

  localparam int IDX_W = $clog2(BUCKET_COUNT);
  localparam int TOT_W = (COUNT_WIDTH + IDX_W > 64) ? 64 : COUNT_WIDTH + IDX_W;
  localparam int TH_W  = 81;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUCKET_COUNT - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_FIND  = 4'd2;
  localparam logic [3:0] S_NEXT  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_QTH   = 4'd6;
  localparam logic [3:0] S_QRD   = 4'd7;
  localparam logic [3:0] S_QCMP  = 4'd8;
  localparam logic [3:0] S_QNEXT = 4'd9;
  localparam logic [3:0] S_QREP  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]             state;
  logic                   clr_resp;
  logic [IDX_W-1:0]       idx;
  logic [63:0]            p;
  logic [TOT_W-1:0]       cum;
  logic [TOT_W-1:0]       total;
  logic [TH_W-1:0]        th;
  logic [2:0]             func_r;
  logic [31:0]            sample_r;
  logic [31:0]            amt_r;
  logic                   clamped;
  logic [47:0]            rep_r;
  logic                   found_r;
  logic [1:0]             status_r;
  logic [30:0]            gamma_q30;
  logic [30:0]            rep_scale_q30;

  logic [COUNT_WIDTH-1:0] mem [BUCKET_COUNT];
  logic [COUNT_WIDTH-1:0] rdata;
  logic                   mem_we;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  logic                   mul_start;
  logic [63:0]            mul_a;
  logic [30:0]            mul_b;
  logic                   mul_done;
  logic [94:0]            mul_prod;
  logic [63:0]            bound_next;
  logic [47:0]            rep_calc;

  logic                   accept;
  logic [TOT_W:0]         cum_sum;
  logic [TOT_W-1:0]       cum_new;
  logic                   q_hit;
  logic [64:0]            merge_sum;
  logic [COUNT_WIDTH-1:0] merge_new;
  logic [COUNT_WIDTH-1:0] merge_added;
  logic [TOT_W:0]         tot_sum;
  logic                   out_free;
  logic                   merge_oob;
  logic [IDX_W-1:0]       merge_idx;
  logic [1:0]             status_base;

  lbqs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign bound_next = mul_prod[94] ? 64'hFFFF_FFFF_FFFF_FFFF : mul_prod[93:30];
  assign rep_calc   = mul_prod[94] ? 48'hFFFF_FFFF_FFFF : mul_prod[93:46];

  assign merge_oob   = (32'(merge_bucket) >= 32'(BUCKET_COUNT));
  assign merge_idx   = merge_oob ? IDX_LAST : IDX_W'(merge_bucket);
  assign status_base = clamped ? lbqs_pkg::STATUS_CLAMPED : lbqs_pkg::STATUS_OK;

  assign cum_sum = {1'b0, cum} + (TOT_W + 1)'(rdata);
  assign cum_new = cum_sum[TOT_W] ? TOT_MAX : cum_sum[TOT_W-1:0];
  assign q_hit   = 96'({cum_new, 16'b0}) >= 96'(th);

  assign merge_sum   = 65'(rdata) + 65'(amt_r);
  assign merge_new   = (merge_sum > 65'(CNT_MAX)) ? CNT_MAX : merge_sum[COUNT_WIDTH-1:0];
  assign merge_added = merge_new - rdata;

  always_comb begin
    tot_sum = {1'b0, total};
    case (func_r)
      lbqs_pkg::FUNC_INSERT: tot_sum = {1'b0, total} + (TOT_W + 1)'(1);
      lbqs_pkg::FUNC_MERGE:  tot_sum = {1'b0, total} + (TOT_W + 1)'(merge_added);
      default:               tot_sum = {1'b0, total};
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = p;
    mul_b     = gamma_q30;
    case (state)
      S_IDLE: begin
        if (accept && func == lbqs_pkg::FUNC_QUANTILE && total != '0) begin
          mul_start = 1'b1;
          mul_a     = 64'(total - TOT_W'(1));
          mul_b     = 31'(q_fraction);
        end
      end
      S_FIND: begin
        mul_start = (p < {sample_r, 32'b0}) && (idx != IDX_LAST);
      end
      S_QCMP: begin
        if (q_hit) begin
          mul_start = 1'b1;
          mul_b     = rep_scale_q30;
        end else begin
          mul_start = (idx != IDX_LAST);
        end
      end
      default: mul_start = 1'b0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    if (state == S_CLR) begin
      mem_we = 1'b1;
    end else if (state == S_UPD) begin
      case (func_r)
        lbqs_pkg::FUNC_INSERT: begin
          mem_we    = (rdata != CNT_MAX);
          mem_wdata = rdata + COUNT_WIDTH'(1);
        end
        lbqs_pkg::FUNC_DELETE: begin
          mem_we    = (rdata != '0);
          mem_wdata = rdata - COUNT_WIDTH'(1);
        end
        lbqs_pkg::FUNC_MERGE: begin
          mem_we    = 1'b1;
          mem_wdata = merge_new;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= mem_wdata;
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_q30     <= lbqs_pkg::GAMMA_RESET;
      rep_scale_q30 <= lbqs_pkg::REP_SCALE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == lbqs_pkg::CFG_GAMMA) begin
        gamma_q30 <= cfg_data;
      end else begin
        rep_scale_q30 <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_resp  <= 1'b0;
      idx       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            func_r   <= func;
            sample_r <= sample_value;
            amt_r    <= merge_amount;
            rep_r    <= '0;
            found_r  <= 1'b0;
            status_r <= lbqs_pkg::STATUS_OK;
            clamped  <= (func == lbqs_pkg::FUNC_MERGE) && merge_oob;
            idx      <= (func == lbqs_pkg::FUNC_MERGE) ? merge_idx : '0;
            p        <= 64'h1_0000_0000;
            case (func)
              lbqs_pkg::FUNC_INSERT, lbqs_pkg::FUNC_DELETE: state <= S_FIND;
              lbqs_pkg::FUNC_QUANTILE: state <= (total != '0) ? S_QTH : S_DONE;
              lbqs_pkg::FUNC_CLEAR: begin
                clr_resp <= 1'b1;
                state    <= S_CLR;
              end
              lbqs_pkg::FUNC_MERGE: state <= S_RD;
              default: state <= S_DONE;
            endcase
          end
        end
        S_CLR: begin
          total <= '0;
          if (idx == IDX_LAST) begin
            idx   <= '0;
            state <= clr_resp ? S_DONE : S_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_FIND: begin
          if (p >= {sample_r, 32'b0}) begin
            state <= S_RD;
          end else if (idx == IDX_LAST) begin
            clamped <= 1'b1;
            state   <= S_RD;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (mul_done) begin
            p     <= bound_next;
            idx   <= idx + IDX_W'(1);
            state <= S_FIND;
          end
        end
        S_RD: begin
          state <= S_UPD;
        end
        S_UPD: begin
          case (func_r)
            lbqs_pkg::FUNC_INSERT: begin
              if (rdata == CNT_MAX) begin
                status_r <= lbqs_pkg::STATUS_SAT;
              end else begin
                status_r <= status_base;
                total    <= tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
              end
            end
            lbqs_pkg::FUNC_DELETE: begin
              if (rdata == '0) begin
                status_r <= lbqs_pkg::STATUS_SAT;
              end else begin
                status_r <= status_base;
                if (total != '0) begin
                  total <= total - TOT_W'(1);
                end
              end
            end
            lbqs_pkg::FUNC_MERGE: begin
              status_r <= (merge_sum > 65'(CNT_MAX)) ? lbqs_pkg::STATUS_SAT : status_base;
              total    <= tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
            end
            default: status_r <= lbqs_pkg::STATUS_OK;
          endcase
          state <= S_DONE;
        end
        S_QTH: begin
          if (mul_done) begin
            th    <= mul_prod[TH_W-1:0];
            cum   <= '0;
            state <= S_QRD;
          end
        end
        S_QRD: begin
          state <= S_QCMP;
        end
        S_QCMP: begin
          cum <= cum_new;
          if (q_hit) begin
            state <= S_QREP;
          end else if (idx == IDX_LAST) begin
            idx   <= '0;
            state <= S_DONE;
          end else begin
            state <= S_QNEXT;
          end
        end
        S_QNEXT: begin
          if (mul_done) begin
            p     <= bound_next;
            idx   <= idx + IDX_W'(1);
            state <= S_QRD;
          end
        end
        S_QREP: begin
          if (mul_done) begin
            rep_r   <= rep_calc;
            found_r <= 1'b1;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            clr_resp <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      bucket_id     <= 11'(idx);
      rep_value_q16 <= rep_r;
      found         <= found_r;
      status        <= status_r;
    end
  end

endmodule
`default_nettype wire

### rtl/core/lbqs_mul.sv
`default_nettype none
module lbqs_mul (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [lbqs_pkg::BOUND_W-1:0]     a,
  input  wire logic [lbqs_pkg::FACTOR_W-1:0]    b,
  output logic                                  done,
  output logic [lbqs_pkg::PROD_W-1:0]           prod
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_SUM  = 2'd2;

  logic [1:0]  phase;
  logic [31:0] a_hi;
  logic [30:0] b_r;
  logic [62:0] m0;
  logic [62:0] m1;
  logic [31:0] mul_x;
  logic [30:0] mul_y;
  logic [62:0] mul_p;

  // one 32x31 multiplier, low half then high half
  assign mul_x = start ? a[31:0] : a_hi;
  assign mul_y = start ? b : b_r;
  assign mul_p = 63'(mul_x) * 63'(mul_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        phase <= PH_HIGH;
      end else if (phase == PH_HIGH) begin
        phase <= PH_SUM;
      end else if (phase == PH_SUM) begin
        phase <= PH_IDLE;
        done  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m0   <= mul_p;
      a_hi <= a[63:32];
      b_r  <= b;
    end
    if (phase == PH_HIGH) begin
      m1 <= mul_p;
    end
    if (phase == PH_SUM) begin
      prod <= {m1, 32'b0} + 95'(m0);
    end
  end

endmodule
`default_nettype wire

### sim/log_bucket_quantile_sketch_check.sv
`timescale 1ns / 1ps
module log_bucket_quantile_sketch_check (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [31:0] sample_value,
  input  wire logic [16:0] q_fraction,
  input  wire logic [10:0] merge_bucket,
  input  wire logic [31:0] merge_amount,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [10:0] bucket_id,
  input  wire logic [47:0] rep_value_q16,
  input  wire logic        found,
  input  wire logic [1:0]  status,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [30:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  localparam int NB = 2048;

  typedef struct packed {
    logic [10:0] idx;
    logic [47:0] rep;
    logic        hit;
    logic [1:0]  st;
  } sketch_result_t;

  logic [31:0] counts [NB];
  logic [63:0] bound [NB];
  logic [63:0] total;
  logic [lbqs_pkg::FACTOR_W-1:0] gamma;
  logic [lbqs_pkg::FACTOR_W-1:0] rep_scale;
  sketch_result_t expected_results [$];

  function automatic logic [63:0] grow_bound(logic [63:0] p);
    logic [94:0] prod;
    prod = {31'b0, p} * {64'b0, gamma};
    if (prod[94]) return '1;
    return prod[93:30];
  endfunction

  function automatic logic [47:0] rep_of(logic [63:0] p);
    logic [94:0] prod;
    prod = {31'b0, p} * {64'b0, rep_scale};
    if (prod[94]) return '1;
    return prod[93:46];
  endfunction

  function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  task automatic rebuild_bounds();
    bound[0] = 64'd1 << 32;
    for (int i = 1; i < NB; i++) bound[i] = grow_bound(bound[i-1]);
  endtask

  task automatic predict_sketch(output sketch_result_t r);
    logic [63:0] target;
    logic [80:0] thresh;
    logic [63:0] cum;
    logic [32:0] sum;
    logic [31:0] nw;
    int b;
    r = '0;
    case (func)
      lbqs_pkg::FUNC_INSERT, lbqs_pkg::FUNC_DELETE: begin
        target = {sample_value, 32'b0};
        b = NB - 1;
        r.st = lbqs_pkg::STATUS_CLAMPED;
        for (int i = 0; i < NB; i++) begin
          if (bound[i] >= target) begin
            b = i;
            r.st = lbqs_pkg::STATUS_OK;
            break;
          end
        end
        r.idx = b[10:0];
        if (func == lbqs_pkg::FUNC_INSERT) begin
          if (counts[b] == '1) r.st = lbqs_pkg::STATUS_SAT;
          else begin
            counts[b]++;
            total = sat_add64(total, 64'd1);
          end
        end else begin
          if (counts[b] == 0) r.st = lbqs_pkg::STATUS_SAT;
          else begin
            counts[b]--;
            if (total != 0) total--;
          end
        end
      end
      lbqs_pkg::FUNC_QUANTILE: begin
        if (total != 0) begin
          thresh = {64'b0, q_fraction} * {17'b0, total - 64'd1};
          cum = 0;
          for (int i = 0; i < NB; i++) begin
            cum = sat_add64(cum, {32'b0, counts[i]});
            if ({1'b0, cum, 16'b0} >= thresh) begin
              r.idx = i[10:0];
              r.hit = 1'b1;
              r.rep = rep_of(bound[i]);
              break;
            end
          end
        end
      end
      lbqs_pkg::FUNC_CLEAR: begin
        foreach (counts[i]) counts[i] = 0;
        total = 0;
      end
      lbqs_pkg::FUNC_MERGE: begin
        sum = {1'b0, counts[merge_bucket]} + {1'b0, merge_amount};
        nw = sum[32] ? '1 : sum[31:0];
        if (sum[32]) r.st = lbqs_pkg::STATUS_SAT;
        total = sat_add64(total, {32'b0, nw - counts[merge_bucket]});
        counts[merge_bucket] = nw;
        r.idx = merge_bucket;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    sketch_result_t e;
    if (rst) begin
      foreach (counts[i]) counts[i] = 0;
      total = 0;
      gamma = lbqs_pkg::GAMMA_RESET;
      rep_scale = lbqs_pkg::REP_SCALE_RESET;
      rebuild_bounds();
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lbqs_pkg::CFG_GAMMA) gamma = cfg_data;
        else rep_scale = cfg_data;
        rebuild_bounds();
      end
      if (in_valid && !in_stall) begin
        predict_sketch(e);
        expected_results.push_back(e);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (bucket_id !== e.idx || rep_value_q16 !== e.rep || found !== e.hit ||
              status !== e.st) begin
            fail_count <= fail_count + 1;
            if (bucket_id !== e.idx)
              $error("bucket_id expected %0d got %0d", e.idx, bucket_id);
            if (rep_value_q16 !== e.rep)
              $error("rep_value_q16 expected %0h got %0h", e.rep, rep_value_q16);
            if (found !== e.hit)
              $error("found expected %0d got %0d", e.hit, found);
            if (status !== e.st)
              $error("status expected %0d got %0d", e.st, status);
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

### sim/log_bucket_quantile_sketch_test.sv
`timescale 1ns / 1ps
module log_bucket_quantile_sketch_test;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  func = 0;
  logic [31:0] sample_value = 0;
  logic [16:0] q_fraction = 0;
  logic [10:0] merge_bucket = 0;
  logic [31:0] merge_amount = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [10:0] bucket_id;
  logic [47:0] rep_value_q16;
  logic        found;
  logic [1:0]  status;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [30:0] cfg_data = 0;
  int          fail_count;
  int          pending;

  logic        calm = 0;
  int          stall_left = 0;
  int          item_count = 0;
  int          setting_count = 1;
  longint      cycles = 0;
  logic [31:0] sample_pool [$];

  always #5 clk = ~clk;

  log_bucket_quantile_sketch dut (.*);
  log_bucket_quantile_sketch_check check (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 40000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || calm) out_stall <= 0;
    else if (stall_left > 0) begin
      out_stall <= 1;
      stall_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1;
      stall_left = $urandom_range(0, 7);
    end else out_stall <= 0;
  end

  task automatic send_item(logic [2:0] f, logic [31:0] s, logic [16:0] q,
                           logic [10:0] mb, logic [31:0] ma);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    sample_value <= s;
    q_fraction <= q;
    merge_bucket <= mb;
    merge_amount <= ma;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item_count++;
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_cfg(logic idx, logic [30:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    setting_count++;
  endtask

  task automatic random_items(int n);
    int r;
    int k;
    logic [31:0] s;
    for (int done = 0; done < n;) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        k = $urandom_range(0, 9);
        s = k < 4 ? $urandom_range(0, 2000) : k < 9 ? $urandom : (k[0] ? '1 : 0);
        sample_pool.push_back(s);
        send_item(lbqs_pkg::FUNC_INSERT, s, 0, 0, 0);
      end else if (r < 55) begin
        if (sample_pool.size() > 0 && $urandom_range(0, 4) != 0) begin
          k = $urandom_range(0, sample_pool.size() - 1);
          s = sample_pool[k];
          sample_pool.delete(k);
        end else s = $urandom;
        send_item(lbqs_pkg::FUNC_DELETE, s, 0, 0, 0);
      end else if (r < 75) begin
        send_item(lbqs_pkg::FUNC_QUANTILE, $urandom, $urandom_range(0, 9) == 0 ?
                  17'($urandom_range(0, 131071)) : 17'($urandom_range(0, 65536)), 0, 0);
      end else if (r < 88) begin
        send_item(lbqs_pkg::FUNC_MERGE, $urandom, 17'($urandom),
                  $urandom_range(0, 4) == 0 ? 11'($urandom) : 11'($urandom_range(0, 1200)),
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 50));
      end else if (r < 90) begin
        sample_pool.delete();
        send_item(lbqs_pkg::FUNC_CLEAR, $urandom, 17'($urandom), 11'($urandom), $urandom);
      end else begin
        send_item(3'($urandom_range(5, 7)), $urandom, 17'($urandom), 11'($urandom),
                  $urandom);
        continue;
      end
      done++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: empty table, extremes, saturation and ignored codes
    send_item(lbqs_pkg::FUNC_QUANTILE, 0, 17'd32768, 0, 0);
    send_item(lbqs_pkg::FUNC_DELETE, 0, 0, 0, 0);
    send_item(lbqs_pkg::FUNC_INSERT, 0, 0, 0, 0);
    send_item(lbqs_pkg::FUNC_INSERT, 1, 0, 0, 0);
    send_item(lbqs_pkg::FUNC_INSERT, 2, 0, 0, 0);
    send_item(lbqs_pkg::FUNC_INSERT, '1, 0, 0, 0);
    send_item(lbqs_pkg::FUNC_QUANTILE, 0, 0, 0, 0);
    send_item(lbqs_pkg::FUNC_QUANTILE, 0, 17'd65536, 0, 0);
    send_item(lbqs_pkg::FUNC_QUANTILE, 0, 17'h1ffff, 0, 0);
    send_item(lbqs_pkg::FUNC_MERGE, 0, 0, 11'd0, '1);
    send_item(lbqs_pkg::FUNC_INSERT, 0, 0, 0, 0);
    send_item(lbqs_pkg::FUNC_MERGE, 0, 0, 11'd2047, '1);
    send_item(lbqs_pkg::FUNC_MERGE, 0, 0, 11'd2047, 32'd1);
    send_item(lbqs_pkg::FUNC_MERGE, 0, 0, 11'd7, 32'd0);
    send_item(lbqs_pkg::FUNC_QUANTILE, 0, 17'd65536, 0, 0);
    send_item(3'd5, '1, '1, '1, '1);
    send_item(3'd6, 0, 0, 0, 0);
    send_item(3'd7, '1, '1, '1, '1);
    send_item(lbqs_pkg::FUNC_CLEAR, 0, 0, 0, 0);
    send_item(lbqs_pkg::FUNC_QUANTILE, 0, 0, 0, 0);
    random_items(75);

    drain();
    write_cfg(lbqs_pkg::CFG_GAMMA, 31'h7fffffff);
    write_cfg(lbqs_pkg::CFG_REP_SCALE, 31'd1073741824);
    send_item(lbqs_pkg::FUNC_INSERT, '1, 0, 0, 0);
    send_item(lbqs_pkg::FUNC_QUANTILE, 0, 17'd65536, 0, 0);
    random_items(40);

    drain();
    write_cfg(lbqs_pkg::CFG_GAMMA, 31'd1073741825);
    write_cfg(lbqs_pkg::CFG_REP_SCALE, 31'd0);
    send_item(lbqs_pkg::FUNC_INSERT, 32'd2, 0, 0, 0);
    send_item(lbqs_pkg::FUNC_INSERT, 32'd1, 0, 0, 0);
    send_item(lbqs_pkg::FUNC_QUANTILE, 0, 17'd65536, 0, 0);
    random_items(35);

    drain();
    write_cfg(lbqs_pkg::CFG_GAMMA, 31'($urandom_range(1073741825, 1200000000)));
    write_cfg(lbqs_pkg::CFG_REP_SCALE, 31'($urandom_range(0, 1073741824)));
    random_items(45);
    calm = 1;
    random_items(43);

    drain();
    repeat (50) @(posedge clk);
    $display("sent %0d items over %0d register settings, incl. clamp, saturation,",
             item_count, setting_count);
    $display("empty-table, rank extremes, clear and ignored function codes");
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
